// ===== rtl/core/itoaf_pkg.sv =====
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// Depends on nothing; every other file in rtl/core imports this package.
`default_nettype none

package itoaf_pkg;

    // Sizing
    localparam int MAX_WIDTH  = 64;   // field width clamp, 24..64
    localparam int VALUE_BITS = 64;   // bits of the value that are used, 8..64

    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    // floor(VALUE_BITS * log10(2)) + 1 decimal digits cover 2**VALUE_BITS - 1
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NDIG       = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;
    localparam int NDIG_W     = $clog2(NDIG + 1);
    localparam int BITS_W     = $clog2(VALUE_BITS + 1);
    localparam int CNT_W      = 7;    // character counts, up to MAX_WIDTH

    typedef enum logic [1:0] {
        RADIX_OCT    = 2'd0,
        RADIX_DEC    = 2'd1,
        RADIX_HEX_UP = 2'd2,
        RADIX_HEX_LO = 2'd3
    } t_radix;

    // ASCII codes
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_UP_A  = 7'h41;
    localparam logic [6:0] CH_LO_A  = 7'h61;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         radix_sel;
        logic               plus_sign;
        logic               space_sign;
        logic               left_justify;
        logic               zero_pad;
        logic [6:0]         field_width;
    } t_in;

    typedef struct packed {
        logic [6:0] char_out;
        logic       last_char;
    } t_out;

    // Sequencer to converter
    typedef struct packed {
        logic start;   // load a new magnitude and begin conversion
        logic shift;   // drop the leading digit
    } t_conv_ctl;

    // Converter to sequencer
    typedef struct packed {
        logic              done;
        logic [NDIG_W-1:0] ndig;
        logic [3:0]        top_digit;
    } t_conv_stat;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic lower);
        logic [3:0] off;
        off = d - 4'd10;
        if (d < 4'd10) begin
            return CH_ZERO + {3'b000, d};
        end else begin
            return (lower ? CH_LO_A : CH_UP_A) + {3'b000, off};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itoaf_conv.sv =====
// Magnitude-to-digit converter: bit-serial binary-to-BCD, direct octal/hex split,
// then one-digit-per-cycle leading-zero strip. Depends on itoaf_pkg.
`default_nettype none

module itoaf_conv (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  itoaf_pkg::t_conv_ctl              i_ctl,
    input  wire [itoaf_pkg::VALUE_BITS-1:0]   i_mag,
    input  wire [1:0]                         i_radix,
    output itoaf_pkg::t_conv_stat             o_stat
);
    import itoaf_pkg::*;

    localparam int DW = 4 * NDIG;

    typedef enum logic [1:0] {
        C_IDLE,
        C_DABBLE,
        C_NORM,
        C_DONE
    } t_cstate;

    t_cstate               r_state,  n_state;
    logic [VALUE_BITS-1:0] r_bin,    n_bin;
    logic [DW-1:0]         r_dig,    n_dig;
    logic [BITS_W-1:0]     r_bits,   n_bits;
    logic [NDIG_W-1:0]     r_ndig,   n_ndig;

    logic [3*NDIG-1:0]     oct_src;
    logic [DW-1:0]         oct_dig;
    logic [DW-1:0]         hex_dig;
    logic [DW-1:0]         adj_dig;

    always_comb begin
        oct_src = (3*NDIG)'(i_mag);
        hex_dig = DW'(i_mag);
        for (int k = 0; k < NDIG; k++) begin
            oct_dig[4*k +: 4] = {1'b0, oct_src[3*k +: 3]};
            // add three to any BCD digit of five or more before the shift
            adj_dig[4*k +: 4] = (r_dig[4*k +: 4] >= 4'd5) ? r_dig[4*k +: 4] + 4'd3
                                                            : r_dig[4*k +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_dig   = r_dig;
        n_bits  = r_bits;
        n_ndig  = r_ndig;
        if (i_ctl.start) begin
            n_ndig = NDIG_W'(NDIG);
            if (i_radix == RADIX_DEC) begin
                n_bin   = i_mag;
                n_dig   = '0;
                n_bits  = BITS_W'(VALUE_BITS);
                n_state = C_DABBLE;
            end else begin
                n_dig   = (i_radix == RADIX_OCT) ? oct_dig : hex_dig;
                n_state = C_NORM;
            end
        end else begin
            unique case (r_state)
                C_IDLE: begin
                end
                C_DABBLE: begin
                    n_dig  = {adj_dig[DW-2:0], r_bin[VALUE_BITS-1]};
                    n_bin  = {r_bin[VALUE_BITS-2:0], 1'b0};
                    n_bits = r_bits - 1'b1;
                    if (r_bits == BITS_W'(1)) begin
                        n_state = C_NORM;
                    end
                end
                C_NORM: begin
                    // strip one leading zero a cycle, keep at least one digit
                    if (r_dig[DW-1 -: 4] == 4'd0 && r_ndig > NDIG_W'(1)) begin
                        n_dig  = {r_dig[DW-5:0], 4'd0};
                        n_ndig = r_ndig - 1'b1;
                    end else begin
                        n_state = C_DONE;
                    end
                end
                C_DONE: begin
                    if (i_ctl.shift) begin
                        n_dig = {r_dig[DW-5:0], 4'd0};
                    end
                end
                default: n_state = C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_ndig  <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_ndig  <= n_ndig;
            r_bits  <= n_bits;
        end
        r_bin <= n_bin;
        r_dig <= n_dig;
    end

    assign o_stat.done      = (r_state == C_DONE);
    assign o_stat.ndig      = r_ndig;
    assign o_stat.top_digit = r_dig[DW-1 -: 4];

endmodule

`default_nettype wire

// ===== rtl/core/integer_to_ascii_formatter_top.sv =====
// Top level of the integer-to-ASCII formatter: input capture, sign and padding
// sequencer, output register. Depends on itoaf_pkg and itoaf_conv.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_in  (itoaf_pkg::t_in)
//  out     | source    | o_out_valid / i_out_ready | o_out (itoaf_pkg::t_out)
//
// One value is handled at a time. Steps per value: capture, bit-serial decimal
// conversion (skipped for octal/hex), leading zero removal (up to NDIG-1 (21)
// zeros) and its finish, the sequencer seeing the converter done, sizing the
// padding, then one character per cycle while the output is not stalled:
// max(field_width clamped to MAX_WIDTH, sign + digits) characters. The bit-serial BCD
// shift and the one-digit-a-cycle normaliser set the latency before the first
// character. Reset is synchronous, active low, and clears all control state.
// A stall on the output holds the character register; the sequencer waits.
`default_nettype none

module integer_to_ascii_formatter_top (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  itoaf_pkg::t_in    i_in,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output itoaf_pkg::t_out   o_out
);
    import itoaf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,   // wait for a transaction
        S_CONV,   // converter busy
        S_PLAN,   // size the padding
        S_PRE,    // leading pad characters
        S_SIGN,   // sign character
        S_DIG,    // magnitude digits, most significant first
        S_POST    // trailing spaces
    } t_state;

    t_state            r_state,    n_state;
    logic [6:0]        r_sign_ch,  n_sign_ch;
    logic              r_has_sign, n_has_sign;
    logic              r_lower,    n_lower;
    logic              r_left,     n_left;
    logic              r_zpad,     n_zpad;
    logic [CNT_W-1:0]  r_width,    n_width;
    logic [CNT_W-1:0]  r_pad,      n_pad;
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    t_out              r_out,      n_out;
    logic              r_out_valid, n_out_valid;

    logic                  in_fire;
    logic                  out_free;
    logic [VALUE_BITS-1:0] in_v;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic [CNT_W-1:0]      text_len;
    logic [CNT_W-1:0]      plan_pad;
    logic [CNT_W-1:0]      ndig_cnt;

    t_conv_ctl  conv_ctl;
    t_conv_stat conv_stat;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    // the output register can take a character this cycle
    assign out_free   = !r_out_valid || i_out_ready;

    // magnitude in unsigned arithmetic, so the most negative value is exact
    assign in_v   = i_in.value[VALUE_BITS-1:0];
    assign in_neg = in_v[VALUE_BITS-1];
    assign in_mag = in_neg ? VALUE_BITS'(~in_v + 1'b1) : in_v;

    assign ndig_cnt = CNT_W'(conv_stat.ndig);
    assign text_len = ndig_cnt + {{(CNT_W-1){1'b0}}, r_has_sign};
    assign plan_pad = (r_width > text_len) ? r_width - text_len : '0;

    assign conv_ctl.start = in_fire;
    assign conv_ctl.shift = (r_state == S_DIG) && out_free;

    itoaf_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (conv_ctl),
        .i_mag   (in_mag),
        .i_radix (i_in.radix_sel),
        .o_stat  (conv_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_sign_ch   = r_sign_ch;
        n_has_sign  = r_has_sign;
        n_lower     = r_lower;
        n_left      = r_left;
        n_zpad      = r_zpad;
        n_width     = r_width;
        n_pad       = r_pad;
        n_cnt       = r_cnt;
        n_out       = r_out;
        // drop the held character once the sink takes it
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    priority if (in_neg) begin
                        n_sign_ch  = CH_MINUS;
                        n_has_sign = 1'b1;
                    end else if (i_in.plus_sign) begin
                        n_sign_ch  = CH_PLUS;
                        n_has_sign = 1'b1;
                    end else if (i_in.space_sign) begin
                        n_sign_ch  = CH_SPACE;
                        n_has_sign = 1'b1;
                    end else begin
                        n_sign_ch  = CH_SPACE;
                        n_has_sign = 1'b0;
                    end
                    n_lower = (i_in.radix_sel == RADIX_HEX_LO);
                    n_left  = i_in.left_justify;
                    n_zpad  = i_in.zero_pad;
                    n_width = (i_in.field_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                                                                     : i_in.field_width;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (conv_stat.done) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_pad = plan_pad;
                priority if (!r_left && plan_pad != '0) begin
                    n_cnt   = plan_pad;
                    n_state = S_PRE;
                end else if (r_has_sign) begin
                    n_state = S_SIGN;
                end else begin
                    n_cnt   = ndig_cnt;
                    n_state = S_DIG;
                end
            end
            S_PRE: begin
                if (out_free) begin
                    // zeros here land before the sign, as spaces would
                    n_out.char_out  = r_zpad ? CH_ZERO : CH_SPACE;
                    n_out.last_char = 1'b0;
                    n_out_valid     = 1'b1;
                    n_cnt           = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        if (r_has_sign) begin
                            n_state = S_SIGN;
                        end else begin
                            n_cnt   = ndig_cnt;
                            n_state = S_DIG;
                        end
                    end
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_out.char_out  = r_sign_ch;
                    n_out.last_char = 1'b0;
                    n_out_valid     = 1'b1;
                    n_cnt           = ndig_cnt;
                    n_state         = S_DIG;
                end
            end
            S_DIG: begin
                if (out_free) begin
                    n_out.char_out  = digit_char(conv_stat.top_digit, r_lower);
                    n_out.last_char = (r_cnt == CNT_W'(1)) && !(r_left && r_pad != '0);
                    n_out_valid     = 1'b1;
                    n_cnt           = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        if (r_left && r_pad != '0) begin
                            n_cnt   = r_pad;
                            n_state = S_POST;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_POST: begin
                if (out_free) begin
                    // left justified padding is always spaces
                    n_out.char_out  = CH_SPACE;
                    n_out.last_char = (r_cnt == CNT_W'(1));
                    n_out_valid     = 1'b1;
                    n_cnt           = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_pad       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_pad       <= n_pad;
        end
        r_sign_ch  <= n_sign_ch;
        r_has_sign <= n_has_sign;
        r_lower    <= n_lower;
        r_left     <= n_left;
        r_zpad     <= n_zpad;
        r_width    <= n_width;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // a captured transaction makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input still ready after a transaction was accepted");

    // no new value is taken while a non-final character of the current one waits
    a_no_accept_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last_char) |-> !o_in_ready)
        else $error("input ready while a value's text is incomplete");

    // digits are only emitted from a finished conversion
    a_digits_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> conv_stat.done)
        else $error("digit emission before conversion finished");

    // pad runs never start empty
    a_pad_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PRE) || (r_state == S_POST)) |-> (r_cnt != '0))
        else $error("pad state entered with zero count");
`endif

endmodule

`default_nettype wire
